FILE: rtl/tlfrs_pkg.sv
package tlfrs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;
    localparam int TIME_BITS_DEF   = 48;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 32;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_FORCE  = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd3;
    localparam logic [OP_W-1:0] OP_PICK   = 3'd4;
    localparam logic [OP_W-1:0] OP_RECORD = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FRONT = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

FILE: rtl/tlfrs_div.sv
module tlfrs_div #(
    parameter int NUM_W = tlfrs_pkg::TIME_BITS_DEF,
    parameter int DEN_W = tlfrs_pkg::CNT_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [NUM_W-1:0]     i_dividend,
    input  logic [DEN_W-1:0]     i_divisor,
    output logic [NUM_W-1:0]     o_quotient,
    output tlfrs_pkg::t_div_sts  o_sts
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] diff;

    assign rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NUM_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            if (!diff[DEN_W]) begin
                r_rem <= diff[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

FILE: rtl/two_level_feedback_request_scheduler_core.sv
// Two-level aging request scheduler.
// Input channel: i_in_valid / o_in_stall carry one transaction (operation, id,
// size, arrival time, current time, availability, use time). Output channel:
// o_out_valid / i_out_stall carry one result (status, granted, chosen_id) for
// every input transaction, in order.
// The block works on one transaction at a time under a small sequencer; both
// queues live in circular memories with registered reads.
// Work per transaction:
//   add, query, unused codes: no queue walk
//   remove: a head check, then a walk over one queue; forced remove walks both
//   pick: aging moves, then a head check or a first-fit walk
//   record use: waits for the bit-serial divider
// o_in_stall is high from accept until the result is loaded into the output register.
// A new transaction is accepted while a finished result waits in the output
// register; if the receiver stalls, the next result holds inside the block.
// Reset empties both queues, clears the average use time and the completed
// count, and drops any pending result.
module two_level_feedback_request_scheduler_core #(
    parameter int QUEUE_DEPTH = tlfrs_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = tlfrs_pkg::ID_BITS_DEF,
    parameter int TIME_BITS   = tlfrs_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tlfrs_pkg::OP_W-1:0]    i_operation,
    input  logic [ID_BITS-1:0]            i_request_id,
    input  logic [TIME_BITS-1:0]          i_request_size,
    input  logic [TIME_BITS-1:0]          i_request_time,
    input  logic [TIME_BITS-1:0]          i_now_time,
    input  logic [TIME_BITS-1:0]          i_availability,
    input  logic [TIME_BITS-1:0]          i_use_time,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tlfrs_pkg::STATUS_W-1:0] o_status,
    output logic                          o_granted,
    output logic [ID_BITS-1:0]            o_chosen_id
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = ID_BITS + 2 * TIME_BITS;
    localparam int HW = ID_BITS + TIME_BITS;
    localparam int NW = tlfrs_pkg::CNT_W;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_ADD     = 13'b0000000000010,
        S_HF_RD   = 13'b0000000000100,
        S_HF_EV   = 13'b0000000001000,
        S_SCAN_RD = 13'b0000000010000,
        S_SCAN_EV = 13'b0000000100000,
        S_ESC_RD  = 13'b0000001000000,
        S_ESC_EV  = 13'b0000010000000,
        S_FIT_RD  = 13'b0000100000000,
        S_FIT_EV  = 13'b0001000000000,
        S_REC     = 13'b0010000000000,
        S_DIV     = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } t_state;

    function automatic logic [QW-1:0] wrap_add(input logic [QW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {{(CW + 1 - QW){1'b0}}, a} + {1'b0, b};
        if (s >= (CW + 1)'(QUEUE_DEPTH)) begin
            s = s - (CW + 1)'(QUEUE_DEPTH);
        end
        return s[QW-1:0];
    endfunction

    t_state r_state;

    logic [LW-1:0] low_mem  [QUEUE_DEPTH];
    logic [HW-1:0] high_mem [QUEUE_DEPTH];
    logic [LW-1:0] r_lrd;
    logic [HW-1:0] r_hrd;

    logic [QW-1:0] r_lh, r_hh;
    logic [CW-1:0] r_lc, r_hc;
    logic [CW-1:0] r_i, r_w;
    logic          r_q;
    logic          r_hit;
    logic [TIME_BITS-1:0] r_avg;
    logic [NW-1:0]        r_cnt;
    logic                 r_up;

    logic [tlfrs_pkg::OP_W-1:0] r_op;
    logic [ID_BITS-1:0]         r_id;
    logic [TIME_BITS-1:0]       r_size, r_time, r_now, r_avail, r_use;

    logic [tlfrs_pkg::STATUS_W-1:0] r_status;
    logic                           r_granted;
    logic [ID_BITS-1:0]             r_chosen;

    logic [ID_BITS-1:0]   lid, hid;
    logic [TIME_BITS-1:0] lsize, ltime, hsize, age;
    logic                 aged, full, match, out_free;
    logic [CW-1:0]        scnt;
    logic [CW:0]          total;
    logic [NW-1:0]        cnt_inc;

    logic                 l_we, h_we;
    logic [QW-1:0]        l_waddr, h_waddr, l_raddr, h_raddr;
    logic [LW-1:0]        l_wdata;
    logic [HW-1:0]        h_wdata;

    logic                 div_start;
    logic [TIME_BITS-1:0] div_num, div_quo;
    tlfrs_pkg::t_div_sts  div_sts;

    assign lid   = r_lrd[LW-1 -: ID_BITS];
    assign lsize = r_lrd[2*TIME_BITS-1 -: TIME_BITS];
    assign ltime = r_lrd[TIME_BITS-1:0];
    assign hid   = r_hrd[HW-1 -: ID_BITS];
    assign hsize = r_hrd[TIME_BITS-1:0];
    assign age   = r_now - ltime;
    assign aged  = age > r_avg;
    assign total = {1'b0, r_lc} + {1'b0, r_hc};
    assign full  = total >= (CW + 1)'(QUEUE_DEPTH);
    assign match = (r_q ? hid : lid) == r_id;
    assign scnt  = r_q ? r_hc : r_lc;
    assign cnt_inc = (r_cnt == '1) ? r_cnt : r_cnt + NW'(1);
    assign out_free = !o_out_valid || !i_out_stall;

    assign l_raddr = wrap_add(r_lh, r_i);
    assign h_raddr = wrap_add(r_hh, r_i);

    assign l_we    = ((r_state == S_ADD) && !full) || ((r_state == S_SCAN_EV) && !r_q && !match);
    assign l_waddr = (r_state == S_ADD) ? wrap_add(r_lh, r_lc) : wrap_add(r_lh, r_w);
    assign l_wdata = (r_state == S_ADD) ? {r_id, r_size, r_time} : r_lrd;
    assign h_we    = ((r_state == S_ESC_EV) && aged) || ((r_state == S_SCAN_EV) && r_q && !match);
    assign h_waddr = (r_state == S_ESC_EV) ? wrap_add(r_hh, r_hc) : wrap_add(r_hh, r_w);
    assign h_wdata = (r_state == S_ESC_EV) ? {lid, lsize} : r_hrd;

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            low_mem[l_waddr] <= l_wdata;
        end
        if (h_we) begin
            high_mem[h_waddr] <= h_wdata;
        end
        r_lrd <= low_mem[l_raddr];
        r_hrd <= high_mem[h_raddr];
    end

    assign div_start = (r_state == S_REC);
    assign div_num   = r_up ? (r_use - r_avg) : (r_avg - r_use);

    tlfrs_div #(
        .NUM_W (TIME_BITS),
        .DEN_W (NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (cnt_inc),
        .o_quotient (div_quo),
        .o_sts      (div_sts)
    );

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_op    <= i_operation;
            r_id    <= i_request_id;
            r_size  <= i_request_size;
            r_time  <= i_request_time;
            r_now   <= i_now_time;
            r_avail <= i_availability;
            r_use   <= i_use_time;
        end
        if (r_state == S_DONE && out_free) begin
            o_status    <= r_status;
            o_granted   <= r_granted;
            o_chosen_id <= r_chosen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lh        <= '0;
            r_hh        <= '0;
            r_lc        <= '0;
            r_hc        <= '0;
            r_i         <= '0;
            r_w         <= '0;
            r_q         <= 1'b0;
            r_hit       <= 1'b0;
            r_avg       <= '0;
            r_cnt       <= '0;
            r_up        <= 1'b0;
            r_status    <= tlfrs_pkg::ST_OK;
            r_granted   <= 1'b0;
            r_chosen    <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_i       <= '0;
                        r_w       <= '0;
                        r_hit     <= 1'b0;
                        r_q       <= 1'b0;
                        r_status  <= tlfrs_pkg::ST_OK;
                        r_granted <= 1'b0;
                        r_chosen  <= '0;
                        case (i_operation)
                            tlfrs_pkg::OP_ADD: r_state <= S_ADD;
                            tlfrs_pkg::OP_REMOVE: begin
                                r_state <= (r_hc != '0) ? S_HF_RD : S_SCAN_RD;
                            end
                            tlfrs_pkg::OP_FORCE: begin
                                r_q     <= 1'b1;
                                r_state <= S_SCAN_RD;
                            end
                            tlfrs_pkg::OP_QUERY: begin
                                if (r_hc == '0) begin
                                    r_granted <= 1'b1;
                                    r_state   <= S_DONE;
                                end else begin
                                    r_state <= S_HF_RD;
                                end
                            end
                            tlfrs_pkg::OP_PICK:   r_state <= S_ESC_RD;
                            tlfrs_pkg::OP_RECORD: r_state <= S_REC;
                            default:              r_state <= S_DONE;
                        endcase
                    end
                end
                S_ADD: begin
                    if (full) begin
                        r_status <= tlfrs_pkg::ST_FULL;
                    end else begin
                        r_lc <= r_lc + CW'(1);
                    end
                    r_state <= S_DONE;
                end
                S_HF_RD: r_state <= S_HF_EV;
                S_HF_EV: begin
                    r_state <= S_DONE;
                    case (r_op)
                        tlfrs_pkg::OP_REMOVE: begin
                            if (hid != r_id) begin
                                r_status <= tlfrs_pkg::ST_NOT_FRONT;
                            end else begin
                                r_q     <= 1'b1;
                                r_state <= S_SCAN_RD;
                            end
                        end
                        tlfrs_pkg::OP_QUERY: r_granted <= (hid == r_id);
                        tlfrs_pkg::OP_PICK: begin
                            if (r_avail >= hsize) begin
                                r_granted <= 1'b1;
                                r_chosen  <= hid;
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_SCAN_RD: begin
                    if (r_i == scnt) begin
                        if (r_q) begin
                            r_hc <= r_w;
                        end else begin
                            r_lc <= r_w;
                        end
                        r_i <= '0;
                        r_w <= '0;
                        if (r_q && r_op == tlfrs_pkg::OP_FORCE) begin
                            r_q <= 1'b0;
                        end else begin
                            if (!r_hit) begin
                                r_status <= tlfrs_pkg::ST_NOT_FOUND;
                            end
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_SCAN_EV;
                    end
                end
                S_SCAN_EV: begin
                    if (match) begin
                        r_hit <= 1'b1;
                    end else begin
                        r_w <= r_w + CW'(1);
                    end
                    r_i     <= r_i + CW'(1);
                    r_state <= S_SCAN_RD;
                end
                S_ESC_RD: begin
                    if (r_lc != '0 && r_hc < CW'(QUEUE_DEPTH)) begin
                        r_state <= S_ESC_EV;
                    end else begin
                        r_state <= (r_hc != '0) ? S_HF_RD : S_FIT_RD;
                    end
                end
                S_ESC_EV: begin
                    if (aged) begin
                        r_hc    <= r_hc + CW'(1);
                        r_lc    <= r_lc - CW'(1);
                        r_lh    <= wrap_add(r_lh, CW'(1));
                        r_state <= S_ESC_RD;
                    end else begin
                        r_state <= (r_hc != '0) ? S_HF_RD : S_FIT_RD;
                    end
                end
                S_FIT_RD: begin
                    r_state <= (r_i == r_lc) ? S_DONE : S_FIT_EV;
                end
                S_FIT_EV: begin
                    if (r_avail >= lsize) begin
                        r_granted <= 1'b1;
                        r_chosen  <= lid;
                        r_state   <= S_DONE;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_FIT_RD;
                    end
                end
                S_REC: begin
                    r_cnt   <= cnt_inc;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_sts.done) begin
                        r_avg   <= r_up ? (r_avg + div_quo) : (r_avg - div_quo);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_IDLE && i_in_valid) begin
                r_up <= (i_use_time >= r_avg);
            end
        end
    end

endmodule

FILE: rtl/tlfrs_chk.sv
module tlfrs_chk #(
    parameter int ID_BITS = tlfrs_pkg::ID_BITS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [tlfrs_pkg::STATUS_W-1:0] o_status,
    input logic                           o_granted,
    input logic [ID_BITS-1:0]             o_chosen_id
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_granted) && $stable(o_chosen_id)))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("accepted a second transaction without working the first");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_granted) |-> (o_status == tlfrs_pkg::ST_OK))
        else $error("grant with error status");

    a_chosen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_granted) |-> (o_chosen_id == '0))
        else $error("chosen id without grant");

endmodule

bind two_level_feedback_request_scheduler_core tlfrs_chk #(
    .ID_BITS (ID_BITS)
) u_tlfrs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_granted   (o_granted),
    .o_chosen_id (o_chosen_id)
);

FILE: tb/two_level_feedback_request_scheduler_core_tb.sv
class sched_scoreboard;
    localparam int DEPTH = 16;

    logic [7:0]  low_id[DEPTH];
    logic [47:0] low_sz[DEPTH];
    logic [47:0] low_tm[DEPTH];
    int          low_n;
    logic [7:0]  high_id[DEPTH];
    logic [47:0] high_sz[DEPTH];
    int          high_n;
    logic [47:0] avg_use;
    logic [31:0] done_cnt;
    logic [10:0] pending_results[$];
    int          errors;

    function new();
        low_n = 0;
        high_n = 0;
        avg_use = '0;
        done_cnt = '0;
        errors = 0;
    endfunction

    function void low_shift(int k);
        for (int i = k; i + 1 < low_n; i++) begin
            low_id[i] = low_id[i+1];
            low_sz[i] = low_sz[i+1];
            low_tm[i] = low_tm[i+1];
        end
        low_n--;
    endfunction

    function void high_shift(int k);
        for (int i = k; i + 1 < high_n; i++) begin
            high_id[i] = high_id[i+1];
            high_sz[i] = high_sz[i+1];
        end
        high_n--;
    endfunction

    function bit low_purge(logic [7:0] id);
        int i;
        bit hit;
        i = 0;
        hit = 0;
        while (i < low_n) begin
            if (low_id[i] == id) begin
                low_shift(i);
                hit = 1;
            end else begin
                i++;
            end
        end
        return hit;
    endfunction

    function bit high_purge(logic [7:0] id);
        int i;
        bit hit;
        i = 0;
        hit = 0;
        while (i < high_n) begin
            if (high_id[i] == id) begin
                high_shift(i);
                hit = 1;
            end else begin
                i++;
            end
        end
        return hit;
    endfunction

    function void note_request(logic [2:0] op, logic [7:0] id, logic [47:0] sz,
                               logic [47:0] rt, logic [47:0] now,
                               logic [47:0] avail, logic [47:0] use_t);
        logic [1:0]  st;
        logic        gr;
        logic [7:0]  ch;
        logic [47:0] age;
        bit          a;
        bit          b;
        st = tlfrs_pkg::ST_OK;
        gr = 0;
        ch = '0;
        case (op)
            tlfrs_pkg::OP_ADD: begin
                if (low_n + high_n >= DEPTH) begin
                    st = tlfrs_pkg::ST_FULL;
                end else begin
                    low_id[low_n] = id;
                    low_sz[low_n] = sz;
                    low_tm[low_n] = rt;
                    low_n++;
                end
            end
            tlfrs_pkg::OP_REMOVE: begin
                if (high_n > 0) begin
                    if (high_id[0] != id) st = tlfrs_pkg::ST_NOT_FRONT;
                    else void'(high_purge(id));
                end else if (!low_purge(id)) begin
                    st = tlfrs_pkg::ST_NOT_FOUND;
                end
            end
            tlfrs_pkg::OP_FORCE: begin
                a = high_purge(id);
                b = low_purge(id);
                if (!a && !b) st = tlfrs_pkg::ST_NOT_FOUND;
            end
            tlfrs_pkg::OP_QUERY: begin
                gr = (high_n == 0 || high_id[0] == id);
            end
            tlfrs_pkg::OP_PICK: begin
                while (low_n > 0 && high_n < DEPTH) begin
                    age = now - low_tm[0];
                    if (age <= avg_use) break;
                    high_id[high_n] = low_id[0];
                    high_sz[high_n] = low_sz[0];
                    high_n++;
                    low_shift(0);
                end
                if (high_n > 0) begin
                    if (avail >= high_sz[0]) begin
                        gr = 1;
                        ch = high_id[0];
                    end
                end else begin
                    for (int i = 0; i < low_n; i++) begin
                        if (avail >= low_sz[i]) begin
                            gr = 1;
                            ch = low_id[i];
                            break;
                        end
                    end
                end
            end
            tlfrs_pkg::OP_RECORD: begin
                if (done_cnt != 32'hFFFF_FFFF) done_cnt++;
                if (use_t >= avg_use) avg_use = avg_use + (use_t - avg_use) / done_cnt;
                else avg_use = avg_use - (avg_use - use_t) / done_cnt;
            end
            default: ;
        endcase
        pending_results.insert(pending_results.size(), {st, gr, ch});
    endfunction

    function void check_result(logic [1:0] st, logic gr, logic [7:0] ch);
        logic [10:0] exp_r;
        if (pending_results.size() == 0) begin
            report("result with nothing pending");
            return;
        end
        exp_r = pending_results.pop_front();
        if (st !== exp_r[10:9]) report($sformatf("status %0d want %0d", st, exp_r[10:9]));
        if (gr !== exp_r[8]) report($sformatf("granted %0d want %0d", gr, exp_r[8]));
        if (ch !== exp_r[7:0]) report($sformatf("chosen_id %0d want %0d", ch, exp_r[7:0]));
    endfunction

    function void report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endfunction
endclass

module two_level_feedback_request_scheduler_core_tb;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic [2:0]  i_operation = '0;
    logic [7:0]  i_request_id = '0;
    logic [47:0] i_request_size = '0;
    logic [47:0] i_request_time = '0;
    logic [47:0] i_now_time = '0;
    logic [47:0] i_availability = '0;
    logic [47:0] i_use_time = '0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [1:0]  o_status;
    logic        o_granted;
    logic [7:0]  o_chosen_id;

    sched_scoreboard sb = new();
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_off = 0;
    int   cycles = 0;
    logic [47:0] clock_now = 48'd1000;
    logic [7:0]  id_pool[8];

    always #5 i_clk = ~i_clk;

    two_level_feedback_request_scheduler_core DUT (.*);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3_000_000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_granted, o_chosen_id);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_stall <= 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_request(i_operation, i_request_id, i_request_size, i_request_time,
                            i_now_time, i_availability, i_use_time);
    end

    task automatic send(logic [2:0] op, logic [7:0] id, logic [47:0] sz,
                        logic [47:0] rt, logic [47:0] now, logic [47:0] avail,
                        logic [47:0] use_t);
        while (($urandom_range(99) < send_idle_pct)) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_operation <= op;
        i_request_id <= id;
        i_request_size <= sz;
        i_request_time <= rt;
        i_now_time <= now;
        i_availability <= avail;
        i_use_time <= use_t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand48();
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        case ($urandom_range(3))
            0: v = v & 48'hFF;
            1: v = v & 48'hFFFF_FFFF;
            default: ;
        endcase
        return v;
    endfunction

    task automatic random_item();
        logic [2:0]  op;
        logic [7:0]  id;
        int          r;
        r = $urandom_range(99);
        if (r < 35) op = tlfrs_pkg::OP_ADD;
        else if (r < 50) op = tlfrs_pkg::OP_PICK;
        else if (r < 62) op = tlfrs_pkg::OP_REMOVE;
        else if (r < 72) op = tlfrs_pkg::OP_FORCE;
        else if (r < 82) op = tlfrs_pkg::OP_QUERY;
        else if (r < 97) op = tlfrs_pkg::OP_RECORD;
        else op = 3'($urandom_range(7));
        id = ($urandom_range(9) < 8) ? id_pool[$urandom_range(7)] : 8'($urandom);
        clock_now = clock_now + $urandom_range(2000);
        if ($urandom_range(49) == 0) clock_now = 48'({$urandom, $urandom});
        send(op, id, ($urandom_range(3) == 0) ? rand48() : 48'($urandom_range(1000)),
             clock_now - $urandom_range(500), clock_now,
             ($urandom_range(3) == 0) ? rand48() : 48'($urandom_range(1200)),
             ($urandom_range(3) == 0) ? rand48() : 48'($urandom_range(3000)));
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    localparam logic [47:0] MAX48 = '1;

    initial begin
        for (int i = 0; i < 8; i++) id_pool[i] = 8'($urandom);
        id_pool[0] = 8'h00;
        id_pool[1] = 8'hFF;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send(tlfrs_pkg::OP_PICK, 8'h00, 0, 0, 0, MAX48, 0);
        send(tlfrs_pkg::OP_REMOVE, 8'h55, 0, 0, 0, 0, 0);
        send(tlfrs_pkg::OP_FORCE, 8'hAA, 0, 0, 0, 0, 0);
        send(tlfrs_pkg::OP_QUERY, 8'h12, 0, 0, 0, 0, 0);
        send(tlfrs_pkg::OP_ADD, 8'hFF, MAX48, MAX48, 0, 0, 0);
        send(tlfrs_pkg::OP_ADD, 8'h00, 48'd0, 48'd0, 0, 0, 0);
        send(tlfrs_pkg::OP_ADD, 8'h00, 48'd5, 48'd10, 0, 0, 0);
        send(tlfrs_pkg::OP_PICK, 8'h00, 0, 0, 48'd0, 48'd0, 0);
        send(tlfrs_pkg::OP_QUERY, 8'h00, 0, 0, 0, 0, 0);
        send(tlfrs_pkg::OP_REMOVE, 8'h00, 0, 0, 0, 0, 0);
        send(tlfrs_pkg::OP_RECORD, 0, 0, 0, 0, 0, MAX48);
        send(tlfrs_pkg::OP_RECORD, 0, 0, 0, 0, 0, 48'd0);
        send(3'd6, 8'hFF, MAX48, MAX48, MAX48, MAX48, MAX48);
        send(3'd7, 8'h00, 0, 0, 0, 0, 0);
        for (int i = 0; i < 17; i++) send(tlfrs_pkg::OP_ADD, 8'(i), 48'(i), 48'd0, 0, 0, 0);
        send(tlfrs_pkg::OP_PICK, 0, 0, 0, MAX48, MAX48, 0);
        send(tlfrs_pkg::OP_REMOVE, 8'h05, 0, 0, 0, 0, 0);
        send(tlfrs_pkg::OP_FORCE, 8'h05, 0, 0, 0, 0, 0);
        for (int i = 0; i < 17; i++) send(tlfrs_pkg::OP_FORCE, 8'(i), 0, 0, 0, 0, 0);
        send(tlfrs_pkg::OP_FORCE, 8'hFF, 0, 0, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                3: begin send_idle_pct = 11; recv_stall_pct = 11; end
                4: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_off = 400; end
            endcase
            for (int n = 0; n < 150; n++) random_item();
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
